>>> design/fvts_pkg.sv
package fvts_pkg;

    localparam int VL_W = 10;
    localparam int ID_W = 31;

    // Operation codes of the input item.
    localparam logic [2:0] OP_ADD_ID   = 3'd0;
    localparam logic [2:0] OP_ADD_AUTO = 3'd1;
    localparam logic [2:0] OP_REMOVE   = 3'd2;
    localparam logic [2:0] OP_SEARCH   = 3'd3;
    localparam logic [2:0] OP_CLEAR    = 3'd4;

    // Status codes of the result item.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_DUP       = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_BAD_LEN   = 3'd4;

    localparam logic signed [31:0] NO_ID = 32'hFFFF_FFFF;
    localparam logic [39:0] SIM_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [ID_W-1:0] ID_MAX = '1;

    typedef struct packed {
        logic [2:0]         op;
        logic [ID_W-1:0]    entry_id;
        logic signed [15:0] element;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] result_id;
        logic [39:0]        similarity;
        logic [10:0]        entry_count;
        logic [ID_W-1:0]    largest_id;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WROW,
        S_COPY,
        S_SEARCH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_tag;

endpackage

>>> design/fvts_mac.sv
module fvts_mac
    import fvts_pkg::*;
#(
    parameter int ACC_W = 42
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clr,
    input  t_mac_tag                 i_tag,
    input  logic signed [15:0]       i_a,
    input  logic signed [15:0]       i_b,
    input  logic [ID_W-1:0]          i_id,
    output logic                     o_busy,
    output logic signed [ACC_W-1:0]  o_best,
    output logic [ID_W-1:0]          o_best_id,
    output logic                     o_found
);

    t_mac_tag                r_tag;
    logic signed [31:0]      r_prod;
    logic [ID_W-1:0]         r_id;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] r_best;
    logic [ID_W-1:0]         r_bid;
    logic                    r_found;
    logic signed [ACC_W-1:0] n_sum;

    // The running sum restarts on the first element of every row.
    always_comb begin
        n_sum = (r_tag.first ? '0 : r_acc) + {{(ACC_W-32){r_prod[31]}}, r_prod};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag   <= '0;
            r_best  <= '0;
            r_found <= 1'b0;
        end else begin
            r_tag  <= i_tag;
            r_prod <= 32'(i_a) * 32'(i_b);
            r_id   <= i_id;
            if (r_tag.valid) begin
                r_acc <= n_sum;
            end
            if (i_clr) begin
                r_best  <= '0;
                r_found <= 1'b0;
            end else if (r_tag.valid && r_tag.last && n_sum > r_best) begin
                // Strictly greater keeps the earliest entry on a tie.
                r_best  <= n_sum;
                r_bid   <= r_id;
                r_found <= 1'b1;
            end
        end
    end

    assign o_busy    = r_tag.valid;
    assign o_best    = r_best;
    assign o_best_id = r_bid;
    assign o_found   = r_found;

endmodule

>>> design/feature_vector_top1_search_table.sv
// Channel   Direction  Handshake               Payload
// cfg       in         i_cfg_we                i_cfg_data (vector_length)
// in        in         i_in_valid / o_in_stall i_in_data (t_in_item)
// out       out        o_out_valid / i_out_stall o_out_data (t_out_item)
//
// Each element transaction that is not the last of a vector is taken without a stall.
// After the last transaction the input stalls while the sequencer works:
// clear, unused codes and refusals go straight to the result, an id scan
// reads the stored ids up to a match, a row write or a row move walks all
// MAX_VECTOR_LEN elements, and a search walks every element of every entry;
// the result register is then loaded. The search time is set by the single
// multiply-accumulate unit and the one read port of the vector memory.
// Reset is synchronous and active low; the memories are not cleared.
// A result waits in the output register while the output is stalled, and the
// next result then holds the input stalled until the register is free.
module feature_vector_top1_search_table
    import fvts_pkg::*;
#(
    parameter int MAX_ENTRIES    = 1024,
    parameter int MAX_VECTOR_LEN = 512
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [VL_W-1:0]  i_cfg_data,
    input  logic             i_in_valid,
    input  t_in_item         i_in_data,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data
);

    localparam int EIW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int KW    = (MAX_VECTOR_LEN > 1) ? $clog2(MAX_VECTOR_LEN) : 1;
    localparam int XW    = $clog2(MAX_VECTOR_LEN + 2);
    localparam int AW    = (MAX_ENTRIES * MAX_VECTOR_LEN > 1) ?
                           $clog2(MAX_ENTRIES * MAX_VECTOR_LEN) : 1;
    localparam int ACC_W = 33 + KW;
    localparam int VDEPTH = MAX_ENTRIES * MAX_VECTOR_LEN;

    // Memories: vector rows, ids and the staging buffer for the incoming vector.
    logic signed [15:0] m_vec [VDEPTH];
    logic [ID_W-1:0]    m_id  [MAX_ENTRIES];
    logic signed [15:0] m_stg [MAX_VECTOR_LEN];

    t_state             r_state, n_state;
    logic [VL_W-1:0]    r_vl;
    logic [XW-1:0]      r_idx, n_idx;
    logic [XW-1:0]      r_len, n_len;
    logic [2:0]         r_op, n_op;
    logic [ID_W-1:0]    r_id, n_id;
    logic [ID_W-1:0]    r_newid, n_newid;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [ID_W-1:0]    r_maxid, n_maxid;
    logic [2:0]         r_status, n_status;
    logic signed [31:0] r_rid, n_rid;
    logic [CW-1:0]      r_e, n_e;
    logic [XW-1:0]      r_k, n_k;
    logic [CW-1:0]      r_dst, n_dst;
    logic               r_ovalid, n_ovalid;
    t_out_item          r_out, n_out;

    // Registered memory read data and their companion tags.
    logic signed [15:0] r_vq;
    logic signed [15:0] r_stq;
    logic [ID_W-1:0]    r_idq;
    logic               r_sv;
    logic [CW-1:0]      r_spos;
    logic               r_dv;
    logic [KW-1:0]      r_kd;
    logic               r_dfirst;
    t_mac_tag           r_p1, n_p1;

    // Memory port controls.
    logic               stg_we;
    logic [KW-1:0]      stg_wa, stg_ra;
    logic               id_we;
    logic [EIW-1:0]     id_wa, id_ra;
    logic [ID_W-1:0]    id_wd;
    logic               vec_we;
    logic [AW-1:0]      vec_wa, vec_ra;
    logic signed [15:0] vec_wd;
    logic               mac_clr;

    logic               in_acc, is_last, len_ok, is_full;
    logic [XW-1:0]      cnt_now;
    logic [CW-1:0]      tail;
    logic               scan_issue, match, row_issue, srch_issue, srch_busy, out_free;
    logic               mac_busy, mac_found;
    logic signed [ACC_W-1:0] mac_best;
    logic [ID_W-1:0]    mac_bid;
    logic [63:0]        best64;

    function automatic logic [AW-1:0] row_addr(input logic [CW-1:0] e,
                                               input logic [KW-1:0] k);
        return AW'(e) * AW'(MAX_VECTOR_LEN) + AW'(k);
    endfunction

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign is_last    = in_acc && i_in_data.last;
    // The element count saturates one above the largest legal length.
    assign cnt_now    = (32'(r_idx) <= MAX_VECTOR_LEN) ? r_idx + XW'(1) : r_idx;
    assign len_ok     = (r_vl != '0) && (32'(r_vl) <= MAX_VECTOR_LEN) &&
                        (32'(cnt_now) == 32'(r_vl));
    assign is_full    = (32'(r_cnt) >= MAX_ENTRIES);
    assign tail       = r_cnt - CW'(1);
    assign scan_issue = (r_e < r_cnt);
    assign match      = r_sv && (r_idq == r_id);
    assign row_issue  = (32'(r_k) < MAX_VECTOR_LEN);
    assign srch_issue = (r_e < r_cnt);
    assign srch_busy  = r_p1.valid || mac_busy;
    assign out_free   = !r_ovalid || !i_out_stall;
    assign best64     = 64'(mac_best);

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (is_last) begin
                    case (i_in_data.op)
                        OP_ADD_ID: begin
                            n_state = (!len_ok || is_full) ? S_DONE : S_SCAN;
                        end
                        OP_ADD_AUTO: begin
                            n_state = (!len_ok || is_full || r_maxid == ID_MAX) ?
                                      S_DONE : S_WROW;
                        end
                        OP_REMOVE: begin
                            n_state = S_SCAN;
                        end
                        OP_SEARCH: begin
                            n_state = (!len_ok || r_cnt == '0) ? S_DONE : S_SEARCH;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (match) begin
                    n_state = (r_op == OP_REMOVE && r_spos < tail) ? S_COPY : S_DONE;
                end else if (!scan_issue && !r_sv) begin
                    n_state = (r_op == OP_ADD_ID) ? S_WROW : S_DONE;
                end
            end
            S_WROW, S_COPY: begin
                if (!row_issue && !r_dv) begin
                    n_state = S_DONE;
                end
            end
            S_SEARCH: begin
                if (!srch_issue && !srch_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath updates and memory controls of each state.
    always_comb begin
        n_idx    = r_idx;
        n_len    = r_len;
        n_op     = r_op;
        n_id     = r_id;
        n_newid  = r_newid;
        n_cnt    = r_cnt;
        n_maxid  = r_maxid;
        n_status = r_status;
        n_rid    = r_rid;
        n_e      = r_e;
        n_k      = r_k;
        n_dst    = r_dst;
        n_out    = r_out;
        n_ovalid = (r_ovalid && i_out_stall);
        n_p1     = '0;
        stg_we   = 1'b0;
        stg_wa   = r_idx[KW-1:0];
        stg_ra   = r_k[KW-1:0];
        id_we    = 1'b0;
        id_wa    = r_cnt[EIW-1:0];
        id_wd    = r_newid;
        id_ra    = r_e[EIW-1:0];
        vec_we   = 1'b0;
        vec_wa   = row_addr(r_cnt, r_kd);
        vec_wd   = (32'(r_kd) < 32'(r_len)) ? r_stq : '0;
        vec_ra   = row_addr(r_e, r_k[KW-1:0]);
        mac_clr  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    stg_we = (32'(r_idx) < MAX_VECTOR_LEN);
                    n_idx  = i_in_data.last ? '0 : cnt_now;
                end
                if (is_last) begin
                    n_len    = cnt_now;
                    n_op     = i_in_data.op;
                    n_id     = i_in_data.entry_id;
                    n_newid  = i_in_data.entry_id;
                    n_e      = '0;
                    n_k      = '0;
                    n_rid    = NO_ID;
                    n_status = ST_OK;
                    mac_clr  = 1'b1;
                    case (i_in_data.op)
                        OP_ADD_ID, OP_ADD_AUTO: begin
                            if (!len_ok) begin
                                n_status = ST_BAD_LEN;
                            end else if (is_full) begin
                                n_status = ST_FULL;
                            end else if (i_in_data.op == OP_ADD_AUTO) begin
                                if (r_maxid == ID_MAX) begin
                                    n_status = ST_DUP;
                                end else begin
                                    n_newid = r_maxid + ID_W'(1);
                                end
                            end
                        end
                        OP_REMOVE: begin
                            n_status = ST_NOT_FOUND;
                        end
                        OP_SEARCH: begin
                            if (!len_ok) begin
                                n_status = ST_BAD_LEN;
                            end
                        end
                        OP_CLEAR: begin
                            n_cnt   = '0;
                            n_maxid = '0;
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_issue) begin
                    n_e = r_e + CW'(1);
                end
                if (match) begin
                    if (r_op == OP_ADD_ID) begin
                        n_status = ST_DUP;
                    end else if (r_spos < tail) begin
                        n_dst = r_spos;
                        n_k   = '0;
                    end else begin
                        n_cnt    = tail;
                        n_status = ST_OK;
                    end
                end
            end
            S_WROW: begin
                id_we = row_issue && (r_k == '0);
                if (row_issue) begin
                    n_k = r_k + XW'(1);
                end
                vec_we = r_dv;
                if (!row_issue && !r_dv) begin
                    n_cnt   = r_cnt + CW'(1);
                    n_maxid = (r_newid > r_maxid) ? r_newid : r_maxid;
                    n_rid   = {1'b0, r_newid};
                end
            end
            S_COPY: begin
                // The tail row and id move into the hole left by the removed entry.
                id_ra  = tail[EIW-1:0];
                vec_ra = row_addr(tail, r_k[KW-1:0]);
                if (row_issue) begin
                    n_k = r_k + XW'(1);
                end
                vec_we = r_dv;
                vec_wa = row_addr(r_dst, r_kd);
                vec_wd = r_vq;
                id_we  = r_dv && r_dfirst;
                id_wa  = r_dst[EIW-1:0];
                id_wd  = r_idq;
                if (!row_issue && !r_dv) begin
                    n_cnt    = tail;
                    n_status = ST_OK;
                end
            end
            S_SEARCH: begin
                if (srch_issue) begin
                    n_p1.valid = 1'b1;
                    n_p1.first = (r_k == '0);
                    n_p1.last  = (r_k == r_len - XW'(1));
                    if (n_p1.last) begin
                        n_k = '0;
                        n_e = r_e + CW'(1);
                    end else begin
                        n_k = r_k + XW'(1);
                    end
                end
                if (!srch_issue && !srch_busy) begin
                    n_rid = mac_found ? {1'b0, mac_bid} : NO_ID;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_ovalid              = 1'b1;
                    n_out.status          = r_status;
                    n_out.result_id       = r_rid;
                    n_out.similarity      = (best64 > 64'(SIM_MAX)) ? SIM_MAX :
                                            best64[39:0];
                    n_out.entry_count     = 11'(r_cnt);
                    n_out.largest_id      = r_maxid;
                end
            end
            default: begin
                n_ovalid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vl     <= VL_W'(128);
            r_idx    <= '0;
            r_cnt    <= '0;
            r_maxid  <= '0;
            r_ovalid <= 1'b0;
            r_sv     <= 1'b0;
            r_dv     <= 1'b0;
            r_p1     <= '0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_we) begin
                r_vl <= i_cfg_data;
            end
            r_idx    <= n_idx;
            r_cnt    <= n_cnt;
            r_maxid  <= n_maxid;
            r_ovalid <= n_ovalid;
            r_sv     <= (r_state == S_SCAN) && scan_issue;
            r_dv     <= (r_state == S_WROW || r_state == S_COPY) && row_issue;
            r_p1     <= n_p1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_op     <= n_op;
        r_id     <= n_id;
        r_newid  <= n_newid;
        r_status <= n_status;
        r_rid    <= n_rid;
        r_e      <= n_e;
        r_k      <= n_k;
        r_dst    <= n_dst;
        r_out    <= n_out;
        r_spos   <= r_e;
        r_kd     <= r_k[KW-1:0];
        r_dfirst <= (r_k == '0);
    end

    always_ff @(posedge i_clk) begin
        if (stg_we) begin
            m_stg[stg_wa] <= i_in_data.element;
        end
        r_stq <= m_stg[stg_ra];
    end

    always_ff @(posedge i_clk) begin
        if (id_we) begin
            m_id[id_wa] <= id_wd;
        end
        r_idq <= m_id[id_ra];
    end

    always_ff @(posedge i_clk) begin
        if (vec_we) begin
            m_vec[vec_wa] <= vec_wd;
        end
        r_vq <= m_vec[vec_ra];
    end

    fvts_mac #(
        .ACC_W(ACC_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clr    (mac_clr),
        .i_tag    (r_p1),
        .i_a      (r_vq),
        .i_b      (r_stq),
        .i_id     (r_idq),
        .o_busy   (mac_busy),
        .o_best   (mac_best),
        .o_best_id(mac_bid),
        .o_found  (mac_found)
    );

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

>>> design/fvts_checker.sv
module fvts_checker
    import fvts_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input t_in_item        i_in_data,
    input logic            o_in_stall,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input t_out_item       o_out_data
);

    // A stalled result stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // The last element of a vector starts the operation and closes the input.
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.last |=> o_in_stall)
        else $error("input open after last element");

    // Refused or failed operations carry no id.
    a_fail_no_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |-> o_out_data.result_id == NO_ID)
        else $error("failed operation returned an id");

    // Similarity is reported only by a successful search with a match.
    a_sim_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.similarity != '0 |-> o_out_data.result_id != NO_ID)
        else $error("similarity without a match");

endmodule

bind feature_vector_top1_search_table fvts_checker u_fvts_checker (.*);

>>> sim/tb_feature_vector_top1_search_table.sv
module tb_feature_vector_top1_search_table;
    import fvts_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam int ROW_LEN     = 512;
    // A configuration value of KEEP in the directed table leaves the register alone.
    localparam int KEEP        = -1;
    // An element value of RND_ELEM in the directed table asks for random elements.
    localparam int RND_ELEM    = 100000;
    // Spare clock cycles waited after the last result before a register write.
    localparam int SETTLE      = 16;
    localparam int RAND_ITEMS  = 400;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      cfg_we = 1'b0;
    logic [VL_W-1:0] cfg_data = '0;
    logic      in_valid = 1'b0;
    t_in_item  in_data = '0;
    logic      in_stall;
    logic      out_valid;
    logic      out_stall = 1'b1;
    t_out_item out_data;

    feature_vector_top1_search_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow copy of the table. It is updated in the order the block accepts
    // transactions, so the expected result of each vector is known at once.
    logic signed [15:0] row_mem [TABLE_DEPTH][ROW_LEN];
    logic [ID_W-1:0]    tag_mem [TABLE_DEPTH];
    logic signed [15:0] query_buf [ROW_LEN];
    int unsigned        n_entries;
    logic [ID_W-1:0]    top_id;
    int unsigned        n_gathered;
    int unsigned        vec_len;

    t_out_item expected_results[$];
    int        errors = 0;

    // Directed checks: when set, these fields replace the computed ones so
    // that the hand-typed values are what the output gets compared with.
    bit                 typed_on = 0;
    logic [2:0]         typed_status;
    logic signed [31:0] typed_id;
    int                 typed_count;

    // Sender and receiver pacing. In quiet phases neither side idles.
    bit quiet = 0;
    bit hold_req = 0;

    task automatic apply_item(input t_in_item it);
        t_out_item r;
        int unsigned n;
        bit len_ok;
        logic [ID_W-1:0] new_id;
        longint acc, best;
        if (n_gathered < ROW_LEN) query_buf[n_gathered] = it.element;
        if (n_gathered <= ROW_LEN) n_gathered++;
        if (!it.last) return;

        n = n_gathered;
        n_gathered = 0;
        len_ok = vec_len >= 1 && vec_len <= ROW_LEN && n == vec_len;
        r.status = ST_OK;
        r.result_id = NO_ID;
        r.similarity = '0;

        if (it.op == OP_ADD_ID || it.op == OP_ADD_AUTO) begin
            if (!len_ok) begin
                r.status = ST_BAD_LEN;
            end else if (n_entries >= TABLE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                if (it.op == OP_ADD_ID) begin
                    new_id = it.entry_id;
                    for (int i = 0; i < n_entries; i++)
                        if (tag_mem[i] == new_id) r.status = ST_DUP;
                end else begin
                    new_id = top_id + 1'b1;
                    if (top_id == ID_MAX) r.status = ST_DUP;
                end
                if (r.status == ST_OK) begin
                    tag_mem[n_entries] = new_id;
                    for (int i = 0; i < ROW_LEN; i++)
                        row_mem[n_entries][i] = (i < n) ? query_buf[i] : 16'sd0;
                    n_entries++;
                    if (new_id > top_id) top_id = new_id;
                    r.result_id = {1'b0, new_id};
                end
            end
        end else if (it.op == OP_REMOVE) begin
            r.status = ST_NOT_FOUND;
            for (int i = 0; i < n_entries; i++) begin
                if (tag_mem[i] == it.entry_id) begin
                    // The last entry fills the hole.
                    tag_mem[i] = tag_mem[n_entries-1];
                    row_mem[i] = row_mem[n_entries-1];
                    n_entries--;
                    r.status = ST_OK;
                    break;
                end
            end
        end else if (it.op == OP_SEARCH) begin
            if (!len_ok) begin
                r.status = ST_BAD_LEN;
            end else begin
                best = 0;
                for (int e = 0; e < n_entries; e++) begin
                    acc = 0;
                    for (int i = 0; i < n; i++)
                        acc += longint'(row_mem[e][i]) * longint'(query_buf[i]);
                    // Strictly greater, so the earliest entry wins a tie.
                    if (acc > best) begin
                        best = acc;
                        r.result_id = {1'b0, tag_mem[e]};
                    end
                end
                r.similarity = (best > longint'(SIM_MAX)) ? SIM_MAX : best[39:0];
            end
        end else if (it.op == OP_CLEAR) begin
            n_entries = 0;
            top_id = '0;
        end

        r.entry_count = n_entries[10:0];
        r.largest_id = top_id;
        if (typed_on) begin
            r.status = typed_status;
            r.result_id = typed_id;
            r.entry_count = typed_count[10:0];
        end
        expected_results.insert(expected_results.size(), r);
    endtask

    // Offers one transaction and waits for the block to take it. Valid stays
    // high into the next transaction when there is no gap to insert, and is
    // dropped by drain_results once the sender stops.
    task automatic send_item(input t_in_item it);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge i_clk); while (in_stall);
        apply_item(it);
    endtask

    function automatic logic signed [15:0] pick_element();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            default: return 16'($urandom());
        endcase
    endfunction

    // Streams one vector: n-1 noise transactions, then the operation itself.
    task automatic send_vector(input logic [2:0] op, input logic [ID_W-1:0] id,
                               input int n, input int fill);
        t_in_item it;
        for (int k = 0; k < n; k++) begin
            it.op = 3'($urandom_range(0, 7));
            it.entry_id = ID_W'($urandom());
            it.element = (fill == RND_ELEM) ? pick_element() : fill[15:0];
            it.last = 1'b0;
            if (k == n - 1) begin
                it.op = op;
                it.entry_id = id;
                it.last = 1'b1;
            end
            send_item(it);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_length(input int v);
        drain_results();
        cfg_we <= 1'b1;
        cfg_data <= v[VL_W-1:0];
        @(posedge i_clk);
        vec_len = v[VL_W-1:0];
        cfg_we <= 1'b0;
    endtask

    // Receiver: a random stall before each result, with one long hold-off on
    // request so that the result register fills and the input backs up.
    initial begin
        int k;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_req = 0;
            end
            k = quiet ? 0 : $urandom_range(0, 15);
            if (k > 0) begin
                out_stall <= 1'b1;
                repeat (k) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            do @(posedge i_clk); while (!out_valid);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result without a pending vector, actual %h", $time, out_data);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (out_data.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, out_data.status);
                    errors++;
                end
                if (out_data.result_id !== want.result_id) begin
                    $display("%0t: result_id expected %0d actual %0d",
                             $time, want.result_id, out_data.result_id);
                    errors++;
                end
                if (out_data.similarity !== want.similarity) begin
                    $display("%0t: similarity expected %0d actual %0d",
                             $time, want.similarity, out_data.similarity);
                    errors++;
                end
                if (out_data.entry_count !== want.entry_count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.entry_count, out_data.entry_count);
                    errors++;
                end
                if (out_data.largest_id !== want.largest_id) begin
                    $display("%0t: largest_id expected %0d actual %0d",
                             $time, want.largest_id, out_data.largest_id);
                    errors++;
                end
            end
        end
    end

    typedef struct {
        int                 cfg;
        logic [2:0]         op;
        logic [ID_W-1:0]    id;
        int                 n;
        int                 fill;
        bit                 typed;
        logic [2:0]         st;
        logic signed [31:0] rid;
        int                 cnt;
    } t_step;

    // Directed table. Rows with typed set carry the status, id and entry
    // count that can be read straight from the behavior.
    t_step steps [25] = '{
        // The reset length is 128 and the table starts empty.
        '{KEEP, OP_SEARCH,   31'd0, 128, 16'h1000, 1, ST_OK, NO_ID, 0},
        '{4,    OP_ADD_ID,   31'd5, 4, 16'h7FFF, 1, ST_OK, 32'sd5, 1},
        '{KEEP, OP_ADD_ID,   31'd5, 4, 16'h7FFF, 1, ST_DUP, NO_ID, 1},
        '{KEEP, OP_ADD_AUTO, 31'd0, 4, -32768, 1, ST_OK, 32'sd6, 2},
        '{KEEP, OP_ADD_ID,   31'd9, 3, 1, 1, ST_BAD_LEN, NO_ID, 2},
        '{KEEP, OP_SEARCH,   31'd0, 5, 1, 1, ST_BAD_LEN, NO_ID, 2},
        '{KEEP, OP_SEARCH,   31'd0, 4, -32768, 0, ST_OK, NO_ID, 0},
        '{KEEP, OP_SEARCH,   31'd0, 4, 0, 1, ST_OK, NO_ID, 2},
        '{KEEP, OP_ADD_ID,   ID_MAX, 4, 1, 1, ST_OK, 32'sh7FFF_FFFF, 3},
        // Auto id after the largest id would not fit in 31 bits.
        '{KEEP, OP_ADD_AUTO, 31'd0, 4, 1, 1, ST_DUP, NO_ID, 3},
        '{KEEP, OP_REMOVE,   31'd5, 1, 3, 1, ST_OK, NO_ID, 2},
        '{KEEP, OP_REMOVE,   31'd5, 1, 3, 1, ST_NOT_FOUND, NO_ID, 2},
        '{KEEP, 3'd5,        31'd1, 1, 0, 1, ST_OK, NO_ID, 2},
        '{KEEP, 3'd7,        ID_MAX, 2, 0, 1, ST_OK, NO_ID, 2},
        '{KEEP, 3'd6,        31'd0, 1, 0, 1, ST_OK, NO_ID, 2},
        // Too many elements: the count saturates past the longest vector.
        '{KEEP, OP_ADD_ID,   31'd3, 514, RND_ELEM, 1, ST_BAD_LEN, NO_ID, 2},
        '{KEEP, OP_SEARCH,   31'd0, 4, RND_ELEM, 0, ST_OK, NO_ID, 0},
        '{KEEP, OP_CLEAR,    31'd0, 1, 0, 1, ST_OK, NO_ID, 0},
        // Short row, then a longer length reads the zero padding.
        '{2,    OP_ADD_ID,   31'd1, 2, 16'h4000, 1, ST_OK, 32'sd1, 1},
        '{4,    OP_SEARCH,   31'd0, 4, 16'h4000, 0, ST_OK, NO_ID, 0},
        '{0,    OP_ADD_AUTO, 31'd0, 1, 1, 1, ST_BAD_LEN, NO_ID, 1},
        '{512,  OP_ADD_AUTO, 31'd0, 512, RND_ELEM, 1, ST_OK, 32'sd2, 2},
        '{KEEP, OP_SEARCH,   31'd0, 512, RND_ELEM, 0, ST_OK, NO_ID, 0},
        '{1023, OP_ADD_AUTO, 31'd0, 1, 1, 1, ST_BAD_LEN, NO_ID, 2},
        '{KEEP, OP_CLEAR,    31'd0, 1, 0, 1, ST_OK, NO_ID, 0}
    };

    initial begin
        int sent;
        int phase;
        int n;
        int r;
        logic [2:0] op;
        logic [ID_W-1:0] id;

        for (int i = 0; i < ROW_LEN; i++) query_buf[i] = '0;
        n_entries = 0;
        top_id = '0;
        n_gathered = 0;
        vec_len = 128;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (steps[s]) begin
            if (steps[s].cfg != KEEP) write_length(steps[s].cfg);
            typed_on = steps[s].typed;
            typed_status = steps[s].st;
            typed_id = steps[s].rid;
            typed_count = steps[s].cnt;
            send_vector(steps[s].op, steps[s].id, steps[s].n, steps[s].fill);
        end
        typed_on = 0;

        // Fill the table to the limit with one-element vectors, refuse further
        // adds, search the full table and then take two entries out.
        write_length(1);
        quiet = 1;
        for (int i = 0; i < TABLE_DEPTH; i++) send_vector(OP_ADD_AUTO, 31'd0, 1, RND_ELEM);
        send_vector(OP_ADD_AUTO, 31'd0, 1, 7);
        send_vector(OP_ADD_ID, 31'd77777, 1, 7);
        send_vector(OP_ADD_ID, 31'd77777, 2, 7);
        send_vector(OP_SEARCH, 31'd0, 1, 16'h7FFF);
        send_vector(OP_SEARCH, 31'd0, 1, -32768);
        send_vector(OP_REMOVE, 31'd1, 1, 0);
        send_vector(OP_REMOVE, 31'd1024, 1, 0);
        send_vector(OP_SEARCH, 31'd0, 1, 16'h7FFF);
        send_vector(OP_CLEAR, 31'd0, 1, 0);
        quiet = 0;

        // Random phases: each picks a length and streams mostly well-formed
        // vectors over a small id pool so that removes and duplicates hit.
        sent = 0;
        phase = 0;
        while (sent < RAND_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 5) write_length(0);
            else if (r < 15) write_length($urandom_range(9, 40));
            else write_length($urandom_range(1, 8));
            quiet = ($urandom_range(0, 3) == 0);
            if (phase == 1) hold_req = 1;
            for (int v = 0; v < 20; v++) begin
                r = $urandom_range(0, 99);
                if (r < 30) op = OP_ADD_ID;
                else if (r < 45) op = OP_ADD_AUTO;
                else if (r < 60) op = OP_REMOVE;
                else if (r < 88) op = OP_SEARCH;
                else if (r < 93) op = OP_CLEAR;
                else op = 3'($urandom_range(5, 7));
                if (n_entries >= 24) op = OP_CLEAR;

                r = $urandom_range(0, 9);
                if (r < 7) id = ID_W'($urandom_range(0, 15));
                else if (r < 9) id = ID_W'($urandom());
                else id = ID_MAX;
                if (op == OP_REMOVE && n_entries > 0 && $urandom_range(0, 1))
                    id = tag_mem[$urandom_range(0, n_entries - 1)];

                if (op == OP_ADD_ID || op == OP_ADD_AUTO || op == OP_SEARCH) begin
                    n = (vec_len == 0) ? 1 : int'(vec_len);
                    if ($urandom_range(0, 9) == 0) n = n + 1;
                    else if ($urandom_range(0, 9) == 0 && n > 1) n = n - 1;
                end else begin
                    n = $urandom_range(1, 3);
                end
                send_vector(op, id, n, RND_ELEM);
                sent += n;
            end
            phase++;
        end

        drain_results();
        if (errors == 0 && expected_results.size() == 0) begin
            $display("feature_vector_top1_search_table: match");
        end else begin
            $display("feature_vector_top1_search_table: mismatch");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run, table fill included.
    initial begin
        #80000000;
        $display("feature_vector_top1_search_table: mismatch");
        $finish;
    end

endmodule
